// ===== hw/rtl/tpn_pkg.sv =====
// Shared types and constants for the tune pair to note decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tpn_pkg;

  typedef struct packed {
    logic       start_of_tune;
    logic [7:0] length_byte;
    logic [7:0] pitch_byte;
  } in_t;

  typedef struct packed {
    logic        is_note;
    logic [11:0] freq_hz;
    logic [15:0] timer_reload;
    logic [15:0] duty_value;
    logic [15:0] duration_ms;
  } out_t;

  // classified entry handed from front to back
  typedef struct packed {
    logic        is_note;
    logic [15:0] span;
    logic [16:0] divisor;
  } job_t;

  localparam logic [1:0] REG_VOLUME  = 2'd0;
  localparam logic [1:0] REG_CPU_MHZ = 2'd1;
  localparam logic [1:0] REG_PWM     = 2'd2;

  localparam logic [7:0]  VOLUME_RESET  = 8'd5;
  localparam logic [7:0]  CPU_MHZ_RESET = 8'd40;
  localparam logic [15:0] PWM_RESET     = 16'd2000;

  localparam logic [7:0]  EXTEND_LEN = 8'd255;
  localparam logic [7:0]  RUN_STEP   = 8'd254;
  localparam logic [7:0]  PITCH_MUL  = 8'd247;
  localparam logic [11:0] PITCH_BASE = 12'd4000;
  localparam logic [23:0] FREQ_NUM   = 24'd10000000;
  localparam logic [16:0] PER_NUM    = 17'd100000;
  localparam logic [16:0] CLK_SCALE  = 17'd100000;
  localparam logic [6:0]  DUR_DIV    = 7'd100;
  localparam logic [7:0]  VOL_MAX    = 8'd11;

endpackage

// ===== hw/rtl/tpn_front.sv =====
// Front end: accepts tune entries, tracks the full-period run and classifies.
// Depends on tpn_pkg.
module tpn_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tpn_pkg::in_t  req,
  output logic          job_valid,
  input  logic          job_stall,
  output tpn_pkg::job_t job
);

  logic [7:0] run_count;
  logic [7:0] run_eff;
  logic       extend;
  logic       accept;

  assign run_eff   = req.start_of_tune ? 8'd0 : run_count;
  assign extend    = (req.length_byte == tpn_pkg::EXTEND_LEN);
  assign req_stall = job_stall;
  assign accept    = req_valid && !req_stall;
  assign job_valid = req_valid && !extend;

  assign job.is_note = (req.pitch_byte != 8'd0);
  assign job.span    = 16'({8'd0, run_eff} * {8'd0, tpn_pkg::RUN_STEP})
                       + {8'd0, req.length_byte};
  assign job.divisor = 17'({9'd0, req.pitch_byte} * {9'd0, tpn_pkg::PITCH_MUL})
                       + {5'd0, tpn_pkg::PITCH_BASE};

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= 8'd0;
    end else if (accept) begin
      run_count <= extend ? run_eff + 8'd1 : 8'd0;
    end
  end

endmodule

// ===== hw/rtl/tpn_queue.sv =====
// Short request queue between front and back.
// Depends on tpn_pkg.
module tpn_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  tpn_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_stall,
  output tpn_pkg::job_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tpn_pkg::job_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_stall = (count == CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tpn_back.sv =====
// Back end: runs the note arithmetic on a shared radix-4 restoring divider
// and holds the result register. Depends on tpn_pkg.
module tpn_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_stall,
  input  tpn_pkg::job_t job,
  input  logic [7:0]    volume,
  input  logic [7:0]    cpu_mhz,
  input  logic [15:0]   pwm_full_reload,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tpn_pkg::out_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_DONE} state_t;
  typedef enum logic [2:0] {OP_FREQ, OP_PER, OP_RELOAD, OP_DUTY, OP_DUR} op_t;

  state_t        state;
  op_t           op;
  tpn_pkg::job_t job_r;
  logic [3:0]    cnt;
  logic [17:0]   rem;
  logic [25:0]   dvd;
  logic [16:0]   dvsr;
  logic          note;
  logic [11:0]   freq;
  logic [9:0]    per;
  logic [15:0]   reload;
  logic [15:0]   duty;
  logic [15:0]   dur;

  logic [17:0] rem_a, rem_b, r1, r2;
  logic [25:0] d1, d2;
  logic        ge_a, ge_b;
  logic [4:0]  vol2;

  assign job_stall = (state != S_IDLE);
  assign vol2 = (volume > tpn_pkg::VOL_MAX) ? {tpn_pkg::VOL_MAX[3:0], 1'b0}
                                            : {volume[3:0], 1'b0};

  always_comb begin
    rem_a = {rem[16:0], dvd[25]};
    ge_a  = (rem_a >= {1'b0, dvsr});
    r1    = ge_a ? rem_a - {1'b0, dvsr} : rem_a;
    d1    = {dvd[24:0], ge_a};
    rem_b = {r1[16:0], d1[25]};
    ge_b  = (rem_b >= {1'b0, dvsr});
    r2    = ge_b ? rem_b - {1'b0, dvsr} : rem_b;
    d2    = {d1[24:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_FREQ;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            note  <= job.is_note;
            op    <= OP_FREQ;
            if (job.is_note) begin
              state <= S_LOAD;
            end else begin
              freq   <= 12'd0;
              reload <= 16'd0;
              duty   <= 16'd0;
              dur    <= job.span;
              state  <= S_DONE;
            end
          end
        end
        S_LOAD: begin
          rem <= 18'd0;
          case (op)
            OP_FREQ: begin
              dvd   <= {tpn_pkg::FREQ_NUM, 2'b00};
              dvsr  <= job_r.divisor;
              cnt   <= 4'd12;
              state <= S_DIV;
            end
            OP_PER: begin
              dvd   <= {1'b0, tpn_pkg::PER_NUM, 8'd0};
              dvsr  <= {5'd0, freq};
              cnt   <= 4'd9;
              state <= S_DIV;
            end
            OP_RELOAD: begin
              dvd   <= 26'({18'd0, cpu_mhz} * {9'd0, tpn_pkg::CLK_SCALE});
              dvsr  <= {5'd0, freq};
              cnt   <= 4'd13;
              state <= S_DIV;
            end
            OP_DUTY: begin
              if (pwm_full_reload == 16'd0) begin
                duty <= 16'hFFFF;
                op   <= OP_DUR;
              end else begin
                dvd   <= {22'({17'd0, vol2} * {6'd0, reload}), 4'd0};
                dvsr  <= {1'b0, pwm_full_reload};
                cnt   <= 4'd11;
                state <= S_DIV;
              end
            end
            OP_DUR: begin
              dvd   <= 26'({10'd0, job_r.span} * {16'd0, per});
              dvsr  <= {10'd0, tpn_pkg::DUR_DIV};
              cnt   <= 4'd13;
              state <= S_DIV;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_DIV: begin
          rem <= r2;
          dvd <= d2;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd1) begin
            case (op)
              OP_FREQ: begin
                freq  <= d2[11:0];
                op    <= OP_PER;
                state <= S_LOAD;
              end
              OP_PER: begin
                per   <= d2[9:0];
                op    <= OP_RELOAD;
                state <= S_LOAD;
              end
              OP_RELOAD: begin
                reload <= d2[15:0];
                op     <= OP_DUTY;
                state  <= S_LOAD;
              end
              OP_DUTY: begin
                duty  <= d2[15:0];
                op    <= OP_DUR;
                state <= S_LOAD;
              end
              default: begin
                dur   <= d2[15:0];
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.is_note      <= note;
            rsp.freq_hz      <= freq;
            rsp.timer_reload <= reload;
            rsp.duty_value   <= duty;
            rsp.duration_ms  <= dur;
            rsp_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt != 4'd0)
    else $error("divider running with zero step count");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dvsr != 17'd0 && rem < {1'b0, dvsr})
    else $error("divider remainder out of range");
  a_rest_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.is_note |-> rsp.freq_hz == 12'd0 &&
      rsp.timer_reload == 16'd0 && rsp.duty_value == 16'd0)
    else $error("rest result carries note fields");
  a_note_freq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_note |-> rsp.freq_hz >= 12'd149 && rsp.freq_hz <= 12'd2500)
    else $error("note frequency out of range");
`endif

endmodule

// ===== hw/rtl/tune_pair_to_note_decoder.sv =====
// Top level of the tune pair to note decoder: configuration registers,
// front end, request queue and back end. Depends on tpn_pkg and tpn_* modules.
//
// Each request is one tune entry (length byte, pitch byte). The front end takes
// an entry when the queue is not full; a length of 255 only extends the
// full-period run and gives no result. Other entries go through a small queue to
// the back end, which produces one result per entry. A rest's result passes
// from the queue through the back end's done state into the output register. A
// note passes from the queue through five divisions (12, 9, 13, 11 and 13 steps,
// each after a load state) on one shared divider retiring two quotient bits per
// cycle, then through the done state into the output register. The back end takes
// no new entry until its result is in the output register. A pwm_full_reload of
// 0 skips the duty division. Up to QUEUE_DEPTH classified entries wait while the
// back end is busy, and a finished result waits in the output register.
// Configuration writes take effect at once and must be made while idle.
module tune_pair_to_note_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tpn_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tpn_pkg::out_t rsp,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  logic [7:0]    volume;
  logic [7:0]    cpu_mhz;
  logic [15:0]   pwm_full_reload;

  logic          f_valid;
  logic          f_stall;
  tpn_pkg::job_t f_job;
  logic          b_valid;
  logic          b_stall;
  tpn_pkg::job_t b_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume          <= tpn_pkg::VOLUME_RESET;
      cpu_mhz         <= tpn_pkg::CPU_MHZ_RESET;
      pwm_full_reload <= tpn_pkg::PWM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tpn_pkg::REG_VOLUME:  volume          <= cfg_data[7:0];
        tpn_pkg::REG_CPU_MHZ: cpu_mhz         <= cfg_data[7:0];
        tpn_pkg::REG_PWM:     pwm_full_reload <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tpn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .job_valid (f_valid),
    .job_stall (f_stall),
    .job       (f_job)
  );

  tpn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_data  (f_job),
    .pop_valid  (b_valid),
    .pop_stall  (b_stall),
    .pop_data   (b_job)
  );

  tpn_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (b_valid),
    .job_stall       (b_stall),
    .job             (b_job),
    .volume          (volume),
    .cpu_mhz         (cpu_mhz),
    .pwm_full_reload (pwm_full_reload),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp             (rsp)
  );

endmodule
